@@ src/class_aware_nms_core_macros.svh @@
// Assertion macros for the class aware suppression core
`ifndef CLASS_AWARE_NMS_CORE_MACROS_SVH
`define CLASS_AWARE_NMS_CORE_MACROS_SVH

// check a consequent in the cycle after the antecedent, ignored under reset
`define CANS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cans assertion failed");

// same check, also active during reset
`define CANS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("cans assertion failed");

`endif

@@ src/cans_pkg.sv @@
// Shared types and constants of the class aware suppression core
package cans_pkg;

   localparam int MAX_BOXES = 64;
   localparam int IDX_W     = $clog2(MAX_BOXES);
   localparam int CNT_W     = $clog2(MAX_BOXES + 1);
   localparam logic [15:0] IOU_THR_RESET = 16'd29491;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        w;
      logic [15:0]        h;
      logic [7:0]         label;
      logic [15:0]        score;
   } box_type;

   typedef struct packed {
      logic             insert;
      logic             deq;
      logic             enq;
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] enq_pos;
      box_type          new_box;
      box_type          enq_box;
   } cell_ctl_type;

   typedef enum logic [4:0] {
      ST_LOAD  = 5'b00001,
      ST_POP   = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

endpackage

@@ src/cans_cell.sv @@
// One slot of the box chain: sorted insertion while loading, queue shift while scanning
module cans_cell
   import cans_pkg::*;
(
   input  logic             clock,
   input  logic [IDX_W-1:0] idx,
   input  cell_ctl_type     ctl,
   input  logic             take_prev,
   input  box_type          prev_box,
   input  box_type          next_box,
   output logic             take,
   output box_type          box
);

   box_type box_ff, box_in;

   // a slot past the fill takes any new box; a lower score yields to it, ties stay ahead
   assign take = (CNT_W'(idx) >= ctl.count) || (ctl.new_box.score > box_ff.score);
   assign box  = box_ff;

   always_comb begin
      box_in = box_ff;
      if (ctl.insert) begin
         if (take_prev) begin
            box_in = prev_box;
         end else if (take) begin
            box_in = ctl.new_box;
         end
      end else begin
         if (ctl.deq) begin
            box_in = next_box;
         end
         if (ctl.enq && (CNT_W'(idx) == ctl.enq_pos)) begin
            box_in = ctl.enq_box;
         end
      end
   end

   always_ff @(posedge clock) begin
      box_ff <= box_in;
   end

endmodule

@@ src/cans_iou.sv @@
// Pipelined overlap test of one box against the current pivot
module cans_iou
   import cans_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] thr,
   input  logic        in_valid,
   input  box_type     pivot,
   input  box_type     cand,
   output logic        out_valid,
   output logic        out_keep,
   output box_type     out_box,
   output logic        busy
);

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   box_type s1_box_ff, s2_box_ff, s3_box_ff, s4_box_ff, s5_box_ff;
   logic s1_same_ff, s2_same_ff, s3_same_ff, s4_same_ff;
   logic [15:0] s1_iw_ff, s1_ih_ff, s1_aw_ff, s1_ah_ff;
   logic [31:0] s2_inter_ff, s2_aa_ff, s2_ba_ff;
   logic [31:0] s3_inter_ff, s4_inter_ff;
   logic [32:0] s3_union_ff;
   logic [32:0] s4_plo_ff;
   logic [31:0] s4_phi_ff;
   logic        s5_keep_ff;

   logic signed [17:0] ax, ay, bx, by, ar, ab, br, bb, x1, y1, x2, y2, dx, dy;
   logic [15:0] iw, ih;
   logic [48:0] lhs, rhs;

   always_comb begin
      ax = 18'(pivot.x);
      ay = 18'(pivot.y);
      bx = 18'(cand.x);
      by = 18'(cand.y);
      ar = ax + $signed({2'b00, pivot.w});
      ab = ay + $signed({2'b00, pivot.h});
      br = bx + $signed({2'b00, cand.w});
      bb = by + $signed({2'b00, cand.h});
      x1 = (ax > bx) ? ax : bx;
      y1 = (ay > by) ? ay : by;
      x2 = (ar < br) ? ar : br;
      y2 = (ab < bb) ? ab : bb;
      dx = x2 - x1;
      dy = y2 - y1;
      iw = (dx > 18'sd0) ? dx[15:0] : 16'd0;
      ih = (dy > 18'sd0) ? dy[15:0] : 16'd0;
      lhs = {1'b0, s4_inter_ff, 16'd0};
      rhs = {s4_phi_ff, 17'd0} + {16'd0, s4_plo_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_box_ff   <= cand;
      s1_same_ff  <= (pivot.label == cand.label);
      s1_iw_ff    <= iw;
      s1_ih_ff    <= ih;
      s1_aw_ff    <= pivot.w;
      s1_ah_ff    <= pivot.h;
      s2_box_ff   <= s1_box_ff;
      s2_same_ff  <= s1_same_ff;
      s2_inter_ff <= s1_iw_ff * s1_ih_ff;
      s2_aa_ff    <= s1_aw_ff * s1_ah_ff;
      s2_ba_ff    <= s1_box_ff.w * s1_box_ff.h;
      s3_box_ff   <= s2_box_ff;
      s3_same_ff  <= s2_same_ff;
      s3_inter_ff <= s2_inter_ff;
      s3_union_ff <= {1'b0, s2_aa_ff} + {1'b0, s2_ba_ff} - {1'b0, s2_inter_ff};
      // split the threshold product into two partial products
      s4_box_ff   <= s3_box_ff;
      s4_same_ff  <= s3_same_ff;
      s4_inter_ff <= s3_inter_ff;
      s4_plo_ff   <= thr * s3_union_ff[16:0];
      s4_phi_ff   <= thr * s3_union_ff[32:17];
      s5_box_ff   <= s4_box_ff;
      s5_keep_ff  <= !(s4_same_ff && (lhs > rhs));
   end

   assign out_valid = s5_valid_ff;
   assign out_keep  = s5_keep_ff;
   assign out_box   = s5_box_ff;
   assign busy = s1_valid_ff | s2_valid_ff | s3_valid_ff | s4_valid_ff | s5_valid_ff;

endmodule

@@ src/class_aware_nms_core.sv @@
// Top level of the class aware greedy suppression core
//
//   port group  direction  handshake             word
//   req_*       in         req_valid/req_stall   one detection box
//   rsp_*       out        rsp_valid/rsp_stall   one kept box
//   csr_*       in         csr_wr_en             iou threshold
//
// Loading inserts each box by a broadcast into the sorted cell chain.
// After set end, each kept box costs one scan of the remaining queue (one box per
// cycle through the five stage overlap pipeline) plus a pop, drain and emit step.
// Reset is synchronous; no clearing pass. A stalled result holds the emit step.
module class_aware_nms_core
   import cans_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_box_x,
   input  logic signed [15:0] req_box_y,
   input  logic [15:0]        req_box_width,
   input  logic [15:0]        req_box_height,
   input  logic [7:0]         req_class_label,
   input  logic [15:0]        req_confidence,
   input  logic               req_set_end,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_kept_x,
   output logic signed [15:0] rsp_kept_y,
   output logic [15:0]        rsp_kept_width,
   output logic [15:0]        rsp_kept_height,
   output logic [7:0]         rsp_kept_label,
   output logic [15:0]        rsp_kept_score,
   output logic               rsp_final_box,
   output logic               rsp_overflowed,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in, scan_ff, scan_in;
   logic ovf_ff, ovf_in;
   logic [15:0] thr_ff;
   box_type pivot_ff, pivot_in;
   logic rsp_valid_ff, rsp_valid_in;
   box_type out_box_ff;
   logic out_final_ff, out_ovf_ff;
   logic out_load;

   cell_ctl_type ctl;
   box_type cell_box [MAX_BOXES];
   logic    cell_take [MAX_BOXES];
   logic req_acc, iou_in, iou_out_valid, iou_keep, iou_busy;
   box_type iou_box, new_box;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_LOAD);

   assign new_box.x     = req_box_x;
   assign new_box.y     = req_box_y;
   assign new_box.w     = req_box_width;
   assign new_box.h     = req_box_height;
   assign new_box.label = req_class_label;
   assign new_box.score = req_confidence;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      scan_in   = scan_ff;
      ovf_in    = ovf_ff;
      pivot_in  = pivot_ff;
      out_load  = 1'b0;
      iou_in    = 1'b0;
      ctl.insert  = 1'b0;
      ctl.deq     = 1'b0;
      ctl.enq     = iou_out_valid && iou_keep;
      ctl.count   = count_ff;
      ctl.new_box = new_box;
      ctl.enq_box = iou_box;
      case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (count_ff < CNT_W'(MAX_BOXES)) begin
                  ctl.insert = 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_set_end) begin
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            ctl.deq  = 1'b1;
            pivot_in = cell_box[0];
            scan_in  = count_ff - 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_ff != '0) begin
               ctl.deq = 1'b1;
               iou_in  = 1'b1;
               scan_in = scan_ff - 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!iou_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               if (count_ff == '0) begin
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_POP;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
      ctl.enq_pos = count_ff - CNT_W'(ctl.deq);
      if (ctl.insert) begin
         count_in = count_ff + 1'b1;
      end else begin
         count_in = count_ff - CNT_W'(ctl.deq) + CNT_W'(ctl.enq);
      end
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         scan_ff      <= '0;
         ovf_ff       <= 1'b0;
         thr_ff       <= IOU_THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pivot_ff <= pivot_in;
      if (out_load) begin
         out_box_ff   <= pivot_ff;
         out_final_ff <= (count_ff == '0);
         out_ovf_ff   <= ovf_ff;
      end
   end

   for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
      cans_cell u_cell (
         .clock     (clock),
         .idx       (IDX_W'(i)),
         .ctl       (ctl),
         .take_prev ((i == 0) ? 1'b0 : cell_take[(i == 0) ? 0 : i - 1]),
         .prev_box  (cell_box[(i == 0) ? 0 : i - 1]),
         .next_box  (cell_box[(i == MAX_BOXES - 1) ? i : i + 1]),
         .take      (cell_take[i]),
         .box       (cell_box[i])
      );
   end

   cans_iou u_iou (
      .clock     (clock),
      .reset     (reset),
      .thr       (thr_ff),
      .in_valid  (iou_in),
      .pivot     (pivot_ff),
      .cand      (cell_box[0]),
      .out_valid (iou_out_valid),
      .out_keep  (iou_keep),
      .out_box   (iou_box),
      .busy      (iou_busy)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kept_x      = out_box_ff.x;
   assign rsp_kept_y      = out_box_ff.y;
   assign rsp_kept_width  = out_box_ff.w;
   assign rsp_kept_height = out_box_ff.h;
   assign rsp_kept_label  = out_box_ff.label;
   assign rsp_kept_score  = out_box_ff.score;
   assign rsp_final_box   = out_final_ff;
   assign rsp_overflowed  = out_ovf_ff;

endmodule

@@ src/cans_checker.sv @@
// Port level checks of the class aware suppression core
`include "class_aware_nms_core_macros.svh"

module cans_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_set_end,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_kept_score
);

   `CANS_ASSERT_NEXT_ALWAYS(a_reset_no_word, clock, reset, !rsp_valid && !req_stall)
   `CANS_ASSERT_NEXT(a_busy_after_end, clock, reset, req_valid && !req_stall && req_set_end, req_stall)
   `CANS_ASSERT_NEXT(a_load_continues, clock, reset, req_valid && !req_stall && !req_set_end, !req_stall)
   `CANS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kept_score))

endmodule

bind class_aware_nms_core cans_checker u_cans_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_set_end    (req_set_end),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kept_score (rsp_kept_score)
);

@@ test/class_aware_nms_core_test.sv @@
// Self-checking testbench for the class aware greedy suppression core
`timescale 1ns / 1ps

class kept_box_board;
   cans_pkg::box_type set_boxes[$];
   bit                set_overflow;
   logic [15:0]       iou_thr;
   cans_pkg::box_type want_box[$];
   bit                want_final[$];
   bit                want_ovf[$];
   int                errors;

   function new();
      iou_thr = cans_pkg::IOU_THR_RESET;
      errors = 0;
      set_overflow = 0;
   endfunction

   function bit overlaps(cans_pkg::box_type a, cans_pkg::box_type b);
      longint ax, ay, bx, by, aw, ah, bw, bh, x1, y1, x2, y2, iw, ih;
      longint unsigned inter, uni;
      ax = a.x; ay = a.y; bx = b.x; by = b.y;
      aw = a.w; ah = a.h; bw = b.w; bh = b.h;
      x1 = ax > bx ? ax : bx;
      y1 = ay > by ? ay : by;
      x2 = (ax + aw) < (bx + bw) ? (ax + aw) : (bx + bw);
      y2 = (ay + ah) < (by + bh) ? (ay + ah) : (by + bh);
      iw = x2 - x1 > 0 ? x2 - x1 : 0;
      ih = y2 - y1 > 0 ? y2 - y1 : 0;
      inter = iw * ih;
      uni = aw * ah + bw * bh - inter;
      return (inter << 16) > longint'(iou_thr) * uni;
   endfunction

   // note an accepted word; on set end work out the kept boxes
   function void note_box(cans_pkg::box_type b, bit set_end);
      cans_pkg::box_type ranked[$];
      bit gone[$];
      int k, n, last;
      if (set_boxes.size() < cans_pkg::MAX_BOXES) set_boxes.insert(set_boxes.size(), b);
      else set_overflow = 1;
      if (!set_end) return;
      foreach (set_boxes[i]) begin
         k = ranked.size();
         while (k > 0 && ranked[k-1].score < set_boxes[i].score) k--;
         ranked.insert(k, set_boxes[i]);
         gone.insert(gone.size(), 1'b0);
      end
      n = ranked.size();
      for (int i = 0; i < n; i++) begin
         if (gone[i]) continue;
         for (int j = i + 1; j < n; j++)
            if (!gone[j] && ranked[i].label == ranked[j].label && overlaps(ranked[i], ranked[j]))
               gone[j] = 1;
      end
      last = -1;
      for (int i = 0; i < n; i++) if (!gone[i]) last = i;
      for (int i = 0; i < n; i++)
         if (!gone[i]) begin
            want_box.insert(want_box.size(), ranked[i]);
            want_final.insert(want_final.size(), i == last);
            want_ovf.insert(want_ovf.size(), set_overflow);
         end
      set_boxes.delete();
      set_overflow = 0;
   endfunction

   function void check_kept(cans_pkg::box_type b, bit fin, bit ovf);
      cans_pkg::box_type e;
      bit ef, eo;
      if (want_box.size() == 0) begin
         $display("%0t unexpected kept box %h", $time, b);
         errors++;
         return;
      end
      e = want_box.pop_front();
      ef = want_final.pop_front();
      eo = want_ovf.pop_front();
      if (e != b) begin
         $display("%0t box mismatch: expected %h actual %h", $time, e, b);
         errors++;
      end
      if (ef != fin) begin
         $display("%0t final_box mismatch: expected %b actual %b", $time, ef, fin);
         errors++;
      end
      if (eo != ovf) begin
         $display("%0t overflowed mismatch: expected %b actual %b", $time, eo, ovf);
         errors++;
      end
   endfunction
endclass

module class_aware_nms_core_test;
   import cans_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   box_type     req_box = '0;
   logic        req_set_end = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   box_type     rsp_box;
   logic        rsp_final_box, rsp_overflowed;
   logic        csr_wr_en = 0;
   logic [15:0] csr_wr_data = '0;
   int          send_idle = 0, recv_idle = 0;
   longint      cycles = 0;
   kept_box_board board = new();

   class_aware_nms_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_box_x(req_box.x), .req_box_y(req_box.y),
      .req_box_width(req_box.w), .req_box_height(req_box.h),
      .req_class_label(req_box.label), .req_confidence(req_box.score),
      .req_set_end(req_set_end),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_kept_x(rsp_box.x), .rsp_kept_y(rsp_box.y),
      .rsp_kept_width(rsp_box.w), .rsp_kept_height(rsp_box.h),
      .rsp_kept_label(rsp_box.label), .rsp_kept_score(rsp_box.score),
      .rsp_final_box(rsp_final_box), .rsp_overflowed(rsp_overflowed),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: random stall, check on accept
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_kept(rsp_box, rsp_final_box, rsp_overflowed);
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // valid stays up between back to back words; drop it only while idling
   task automatic send_box(box_type b, bit last);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_box <= b;
      req_set_end <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_box(b, last);
   endtask

   task automatic wait_drain();
      req_valid <= 0;
      while (board.want_box.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_thr(logic [15:0] v);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      board.iou_thr = v;
      @(posedge clock);
   endtask

   function automatic box_type rand_box();
      box_type b;
      b.x = 16'($urandom); b.y = 16'($urandom); b.w = 16'($urandom); b.h = 16'($urandom);
      b.label = 8'($urandom); b.score = 16'($urandom);
      return b;
   endfunction

   // cluster of boxes near a center so that suppression really happens
   function automatic box_type near_box(box_type c);
      box_type b;
      b = c;
      b.x = c.x + $signed(16'($urandom_range(64))) - 16'sd32;
      b.y = c.y + $signed(16'($urandom_range(64))) - 16'sd32;
      b.w = c.w + 16'($urandom_range(40));
      b.h = c.h + 16'($urandom_range(40));
      b.label = 8'($urandom_range(2));
      b.score = ($urandom_range(3) == 0) ? c.score : 16'($urandom);
      return b;
   endfunction

   task automatic random_set(int n);
      box_type c, b;
      c = rand_box();
      c.x = 16'($urandom_range(8000)); c.y = 16'($urandom_range(8000));
      c.w = 16'($urandom_range(400) + 16); c.h = 16'($urandom_range(400) + 16);
      for (int i = 0; i < n; i++) begin
         b = ($urandom_range(9) == 0) ? rand_box() : near_box(c);
         send_box(b, i == n - 1);
      end
   endtask

   task automatic run_phase(int items);
      int sent, n;
      sent = 0;
      while (sent < items) begin
         n = ($urandom_range(19) == 0) ? $urandom_range(70, 64) : $urandom_range(1, 10);
         random_set(n);
         sent += n;
      end
   endtask

   initial begin
      box_type b;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // extremes of the fields, each in a set of one box
      b = '{x: 16'sh7fff, y: -16'sh8000, w: 16'hffff, h: 16'hffff, label: 8'hff,
            score: 16'hffff};
      send_box(b, 1);
      send_box('0, 1);
      // identical boxes, tie scores, degenerate zero size
      b = '{x: 16'sd100, y: 16'sd100, w: 16'd50, h: 16'd50, label: 8'd3, score: 16'd9};
      send_box(b, 0);
      send_box(b, 0);
      b.label = 8'd4;
      send_box(b, 0);
      b.w = 0; b.h = 0;
      send_box(b, 0);
      send_box(b, 1);
      wait_drain();
      write_thr(16'd0);
      random_set(6);
      wait_drain();
      write_thr(16'hffff);
      random_set(6);
      // store full: overflow, then set end on a dropped box
      for (int i = 0; i < MAX_BOXES + 1; i++) send_box(rand_box(), i == MAX_BOXES);
      wait_drain();
      write_thr(16'd32768);

      send_idle = 11; recv_idle = 76;
      run_phase(140);
      // hold off until every kept box has come out
      wait_drain();
      write_thr(16'($urandom));
      send_idle = 76; recv_idle = 11;
      run_phase(140);
      wait_drain();
      write_thr(IOU_THR_RESET);
      send_idle = 0; recv_idle = 0;
      run_phase(140);
      wait_drain();

      if (board.errors == 0 && board.want_box.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+src
src/cans_pkg.sv
src/cans_cell.sv
src/cans_iou.sv
src/class_aware_nms_core.sv
src/cans_checker.sv
test/class_aware_nms_core_test.sv
